### rtl/rprc_pkg.sv
package rprc_pkg;

    localparam int DATA_W     = 8;
    localparam int COUNT_W    = 21;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RELAX_RADIUS = 2'd2;

    localparam logic [DATA_W-1:0] CLASS_ONE  = 8'd1;
    localparam logic [DATA_W-1:0] CLASS_ZERO = 8'd0;

    // One pending centre pixel of the current row and what its window has seen so far.
    typedef struct packed {
        logic valid;
        logic cp;
        logic cr;
        logic hp;
        logic hr;
    } t_cell;

    typedef struct packed {
        logic en;
        logic clear;
        logic last;
        logic row_end;
        logic v_p;
        logic v_r;
    } t_cell_ctl;

endpackage

### rtl/relaxed_precision_recall_counter.sv
// Counts relaxed precision and recall hits over one frame of paired prediction and label
// pixels, one pixel beat per cycle in raster order while o_in_stall is low. Per-column
// distance counters in a line RAM give the vertical part of the window, a line store of
// radius+1 rows delays the centre flags, and a row of MAX_RADIUS+1 cells resolves the
// horizontal part. After the last pixel of a frame the block runs radius rows of width
// internal beats to close the windows of the bottom rows, stalling input meanwhile. The
// two counts appear as one beat once the last internal beat, or the last pixel when the
// radius is zero, has passed through stage registers A and B into the output register.
// Any register write restarts the frame.
module relaxed_precision_recall_counter #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_RADIUS = 7
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [rprc_pkg::DATA_W-1:0]       i_pred_value,
    input  logic [rprc_pkg::DATA_W-1:0]       i_label_value,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [rprc_pkg::COUNT_W-1:0]      o_precision_hits,
    output logic [rprc_pkg::COUNT_W-1:0]      o_recall_hits,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [rprc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rprc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int YW    = $clog2(MAX_HEIGHT + MAX_RADIUS + 1);
    localparam int RW    = (MAX_RADIUS > 0) ? $clog2(MAX_RADIUS + 1) : 1;
    localparam int NCELL = MAX_RADIUS + 1;
    localparam int DW    = $clog2(2 * MAX_RADIUS + 2);
    localparam int CAP   = 2 * MAX_RADIUS + 1;
    localparam int GW    = (MAX_RADIUS > 0) ? MAX_RADIUS : 1;
    localparam int LAW   = RW + XW;
    localparam int SUMW  = $clog2(NCELL + 1);
    localparam int CW    = rprc_pkg::COUNT_W;
    localparam int W_RST = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
    localparam int H_RST = (MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024;
    localparam int R_RST = (MAX_RADIUS < 3) ? MAX_RADIUS : 3;

    typedef struct packed {
        logic          valid;
        logic [XW-1:0] x;
        logic          first;
        logic          ta;
        logic          tb;
        logic          cp;
        logic          cr;
        logic          real_px;
        logic          center;
        logic          row_end;
        logic          frame_end;
        logic [RW-1:0] ws;
    } t_stage_a;

    typedef struct packed {
        logic valid;
        logic cp;
        logic cr;
        logic vp;
        logic vr;
        logic row_end;
        logic frame_end;
    } t_stage_b;

    logic [WW-1:0] r_w;
    logic [HW-1:0] r_h;
    logic [RW-1:0] r_r;
    logic [XW-1:0] r_x;
    logic [YW-1:0] r_y;
    logic [RW-1:0] r_ws;
    logic          r_flush;
    t_stage_a      r_a;
    t_stage_a      a_n;
    t_stage_b      r_b;
    t_stage_b      b_n;
    logic          r_last_v;
    logic [XW-1:0] r_last_x;
    logic [2*DW-1:0] r_last_d;
    logic          r_lbyp;
    logic [1:0]    r_lbyp_d;
    logic [GW-1:0] r_hist_p;
    logic [GW-1:0] r_hist_r;
    logic [CW-1:0] r_pcnt;
    logic [CW-1:0] r_rcnt;
    logic          r_out_valid;
    logic [CW-1:0] r_out_p;
    logic [CW-1:0] r_out_r;

    logic          cfg_we;
    logic [WW-1:0] cfg_w;
    logic [HW-1:0] cfg_h;
    logic [RW-1:0] cfg_r;
    logic          adv;
    logic          src_go;
    logic          x_end;
    logic          y_last;
    logic          y_flush_last;
    logic          frame_end;
    logic [RW-1:0] rs;
    logic [2*DW-1:0] dist_rd;
    logic [2*DW-1:0] dist_old;
    logic [2*DW-1:0] dist_new;
    logic [DW-1:0] da;
    logic [DW-1:0] db;
    logic [DW-1:0] da_n;
    logic [DW-1:0] db_n;
    logic [DW-1:0] two_r;
    logic [1:0]    line_rd;
    logic [1:0]    line_val;
    logic          line_we;
    logic [GW-1:0] hmask;
    logic          b_en;
    logic          b_fin;
    logic [SUMW-1:0] sum_p;
    logic [SUMW-1:0] sum_r;
    logic [NCELL-1:0] hit_p;
    logic [NCELL-1:0] hit_r;
    rprc_pkg::t_cell cell_in  [NCELL];
    rprc_pkg::t_cell cell_out [NCELL];
    rprc_pkg::t_cell_ctl cell_ctl [NCELL];

    assign o_cfg_ready = 1'b1;

    always_comb begin
        cfg_we = 1'b0;
        case (i_cfg_index)
            rprc_pkg::CFG_IMAGE_WIDTH,
            rprc_pkg::CFG_IMAGE_HEIGHT,
            rprc_pkg::CFG_RELAX_RADIUS: cfg_we = i_cfg_valid;
            default: cfg_we = 1'b0;
        endcase
        if (i_cfg_data == '0) begin
            cfg_w = WW'(1);
            cfg_h = HW'(1);
        end else begin
            cfg_w = (32'(i_cfg_data) > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(i_cfg_data);
            cfg_h = (32'(i_cfg_data) > 32'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(i_cfg_data);
        end
        cfg_r = (32'(i_cfg_data[2:0]) > 32'(MAX_RADIUS)) ? RW'(MAX_RADIUS) : RW'(i_cfg_data[2:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w <= WW'(W_RST);
            r_h <= HW'(H_RST);
            r_r <= RW'(R_RST);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                rprc_pkg::CFG_IMAGE_WIDTH:  r_w <= cfg_w;
                rprc_pkg::CFG_IMAGE_HEIGHT: r_h <= cfg_h;
                rprc_pkg::CFG_RELAX_RADIUS: r_r <= cfg_r;
                default: ;
            endcase
        end
    end

    // Source of beats: real pixels, then radius rows of internal beats with no targets.
    assign adv          = ~(r_b.valid & r_b.frame_end & r_out_valid & i_out_stall);
    assign o_in_stall   = ~adv | r_flush;
    assign src_go       = adv & (r_flush | i_in_valid);
    assign x_end        = (r_x == XW'(r_w - WW'(1)));
    assign y_last       = (r_y == YW'(32'(r_h) - 1));
    assign y_flush_last = (r_y == YW'(32'(r_h) - 1 + 32'(r_r)));
    assign frame_end    = x_end & ((~r_flush & y_last & (r_r == '0)) | (r_flush & y_flush_last));
    assign rs           = (r_ws == r_r) ? '0 : r_ws + RW'(1);

    always_comb begin
        a_n           = '0;
        a_n.valid     = src_go;
        a_n.x         = r_x;
        a_n.first     = (r_y == '0);
        a_n.real_px   = ~r_flush;
        a_n.ta        = ~r_flush & (i_label_value == rprc_pkg::CLASS_ONE);
        a_n.tb        = ~r_flush & (i_pred_value == rprc_pkg::CLASS_ONE);
        a_n.cp        = (i_pred_value == rprc_pkg::CLASS_ONE);
        a_n.cr        = (i_label_value != rprc_pkg::CLASS_ZERO);
        a_n.center    = (r_y >= YW'(r_r));
        a_n.row_end   = x_end;
        a_n.frame_end = frame_end;
        a_n.ws        = r_ws;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_we) begin
            r_x     <= '0;
            r_y     <= '0;
            r_ws    <= '0;
            r_flush <= 1'b0;
        end else if (src_go) begin
            if (x_end) begin
                r_x <= '0;
                if (frame_end) begin
                    r_y     <= '0;
                    r_ws    <= '0;
                    r_flush <= 1'b0;
                end else begin
                    r_y  <= r_y + YW'(1);
                    r_ws <= rs;
                    if (~r_flush & y_last) begin
                        r_flush <= 1'b1;
                    end
                end
            end else begin
                r_x <= r_x + XW'(1);
            end
        end
    end

    rprc_ram #(.WIDTH(2 * DW), .DEPTH(2 ** XW)) u_dist_ram (
        .i_clk   (i_clk),
        .i_we    (adv & r_a.valid),
        .i_waddr (r_a.x),
        .i_wdata (dist_new),
        .i_re    (src_go),
        .i_raddr (r_x),
        .o_rdata (dist_rd)
    );

    assign line_we = adv & r_a.valid & r_a.real_px;

    rprc_ram #(.WIDTH(2), .DEPTH(2 ** LAW)) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (line_we),
        .i_waddr ({r_a.ws, r_a.x}),
        .i_wdata ({r_a.cp, r_a.cr}),
        .i_re    (src_go),
        .i_raddr ({rs, r_x}),
        .o_rdata (line_rd)
    );

    // A line entry written at the edge that reads it is taken from the write side.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lbyp   <= 1'b0;
            r_lbyp_d <= '0;
        end else if (src_go) begin
            r_lbyp   <= line_we & ({r_a.ws, r_a.x} == {rs, r_x});
            r_lbyp_d <= {r_a.cp, r_a.cr};
        end
    end

    assign line_val = r_lbyp ? r_lbyp_d : line_rd;

    // Vertical part: rows since the last target in each column.
    always_comb begin
        dist_old = (r_last_v && r_last_x == r_a.x) ? r_last_d : dist_rd;
        da       = dist_old[2*DW-1:DW];
        db       = dist_old[DW-1:0];
        two_r    = DW'(r_r) << 1;
        if (r_a.ta) begin
            da_n = '0;
        end else if (r_a.first || da == DW'(CAP)) begin
            da_n = DW'(CAP);
        end else begin
            da_n = da + DW'(1);
        end
        if (r_a.tb) begin
            db_n = '0;
        end else if (r_a.first || db == DW'(CAP)) begin
            db_n = DW'(CAP);
        end else begin
            db_n = db + DW'(1);
        end
        dist_new     = {da_n, db_n};
        b_n          = '0;
        b_n.valid    = r_a.valid & r_a.center;
        b_n.cp       = (r_r == '0) ? r_a.cp : line_val[1];
        b_n.cr       = (r_r == '0) ? r_a.cr : line_val[0];
        b_n.vp       = (da_n <= two_r);
        b_n.vr       = (db_n <= two_r);
        b_n.row_end  = r_a.row_end;
        b_n.frame_end = r_a.frame_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_we) begin
            r_a.valid <= 1'b0;
            r_b.valid <= 1'b0;
            r_last_v  <= 1'b0;
        end else if (adv) begin
            r_a      <= a_n;
            r_b      <= b_n;
            r_last_v <= r_a.valid;
            r_last_x <= r_a.x;
            r_last_d <= dist_new;
        end
    end

    // Horizontal part: a row of cells, cell k holding the centre k columns back.
    assign b_en  = adv & r_b.valid;
    assign b_fin = b_en & r_b.frame_end;
    assign hmask = GW'((32'd1 << r_r) - 32'd1);

    always_comb begin
        cell_in[0].valid = 1'b1;
        cell_in[0].cp    = r_b.cp;
        cell_in[0].cr    = r_b.cr;
        cell_in[0].hp    = |(r_hist_p & hmask);
        cell_in[0].hr    = |(r_hist_r & hmask);
        for (int k = 1; k < NCELL; k++) begin
            cell_in[k] = cell_out[k-1];
        end
        for (int k = 0; k < NCELL; k++) begin
            cell_ctl[k].en      = b_en;
            cell_ctl[k].clear   = cfg_we;
            cell_ctl[k].last    = (r_r == RW'(k));
            cell_ctl[k].row_end = r_b.row_end;
            cell_ctl[k].v_p     = r_b.vp;
            cell_ctl[k].v_r     = r_b.vr;
        end
    end

    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        rprc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (cell_ctl[k]),
            .i_prev  (cell_in[k]),
            .o_cell  (cell_out[k]),
            .o_hit_p (hit_p[k]),
            .o_hit_r (hit_r[k])
        );
    end

    always_comb begin
        sum_p = '0;
        sum_r = '0;
        for (int k = 0; k < NCELL; k++) begin
            sum_p = sum_p + SUMW'(hit_p[k]);
            sum_r = sum_r + SUMW'(hit_r[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_we) begin
            r_hist_p <= '0;
            r_hist_r <= '0;
            r_pcnt   <= '0;
            r_rcnt   <= '0;
        end else if (b_en) begin
            r_hist_p <= r_b.row_end ? '0 : ((r_hist_p << 1) | GW'(r_b.vp));
            r_hist_r <= r_b.row_end ? '0 : ((r_hist_r << 1) | GW'(r_b.vr));
            if (r_b.frame_end) begin
                r_pcnt <= '0;
                r_rcnt <= '0;
            end else begin
                r_pcnt <= r_pcnt + CW'(sum_p);
                r_rcnt <= r_rcnt + CW'(sum_r);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (b_fin) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_fin) begin
            r_out_p <= r_pcnt + CW'(sum_p);
            r_out_r <= r_rcnt + CW'(sum_r);
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_precision_hits = r_out_p;
    assign o_recall_hits    = r_out_r;

endmodule

### rtl/rprc_ram.sv
module rprc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/rprc_cell.sv
module rprc_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rprc_pkg::t_cell_ctl i_ctl,
    input  rprc_pkg::t_cell     i_prev,
    output rprc_pkg::t_cell     o_cell,
    output logic                o_hit_p,
    output logic                o_hit_r
);

    rprc_pkg::t_cell r_cell;
    rprc_pkg::t_cell upd;
    rprc_pkg::t_cell n_cell;
    logic            retire;

    always_comb begin
        upd    = i_prev;
        upd.hp = i_prev.hp | i_ctl.v_p;
        upd.hr = i_prev.hr | i_ctl.v_r;
        retire = upd.valid & (i_ctl.last | i_ctl.row_end);
        o_hit_p = i_ctl.en & retire & upd.cp & upd.hp;
        o_hit_r = i_ctl.en & retire & upd.cr & upd.hr;
        n_cell       = upd;
        n_cell.valid = upd.valid & ~retire;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_cell <= '0;
        end else if (i_ctl.en) begin
            r_cell <= n_cell;
        end
    end

    assign o_cell = r_cell;

endmodule

### verif/testbench.sv
module testbench;

    typedef struct packed {
        logic [rprc_pkg::DATA_W-1:0] pred;
        logic [rprc_pkg::DATA_W-1:0] label;
    } t_pixel;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_in_valid;
    logic                            o_in_stall;
    logic [rprc_pkg::DATA_W-1:0]     i_pred_value;
    logic [rprc_pkg::DATA_W-1:0]     i_label_value;
    logic                            o_out_valid;
    logic                            i_out_stall;
    logic [rprc_pkg::COUNT_W-1:0]    o_precision_hits;
    logic [rprc_pkg::COUNT_W-1:0]    o_recall_hits;
    logic                            i_cfg_valid;
    logic                            o_cfg_ready;
    logic [rprc_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [rprc_pkg::CFG_DATA_W-1:0] i_cfg_data;

    relaxed_precision_recall_counter dut (.*);

    t_pixel                       pixel_queue[$];
    logic [rprc_pkg::COUNT_W-1:0] exp_precision[$];
    logic [rprc_pkg::COUNT_W-1:0] exp_recall[$];
    int                 mismatches = 0;
    bit                 quiet = 0;
    bit                 long_hold = 0;
    bit                 in_taken = 0;
    int                 in_gap = 0;
    int                 out_burst = 0;
    int                 hold_cnt = 0;
    int                 sent_random = 0;

    logic [2:0]  frame_flags [0:1048575];
    int unsigned cur_w = 1024, cur_h = 1024, cur_r = 3;
    int unsigned col = 0, row = 0;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic int unsigned window_hits(int unsigned w, int unsigned h,
                                                int unsigned r, int centre, int target);
        int unsigned n;
        int y0, y1, x0, x1;
        bit found;
        n = 0;
        for (int y = 0; y < h; y++) begin
            for (int x = 0; x < w; x++) begin
                if (frame_flags[y*w+x][centre]) begin
                    y0 = (y >= r) ? y - r : 0;
                    y1 = (y + r < h) ? y + r : h - 1;
                    x0 = (x >= r) ? x - r : 0;
                    x1 = (x + r < w) ? x + r : w - 1;
                    found = 0;
                    for (int yy = y0; yy <= y1; yy++)
                        for (int xx = x0; xx <= x1; xx++)
                            if (frame_flags[yy*w+xx][target]) found = 1;
                    if (found) n++;
                end
            end
        end
        return n;
    endfunction

    // Predictor and checker: both sample on the rising edge.
    always @(posedge i_clk) begin
        int unsigned w, h, r;
        in_taken <= i_in_valid && !o_in_stall;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (exp_precision.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: %0d %0d", o_precision_hits, o_recall_hits);
            end else begin
                if (o_precision_hits !== exp_precision[0] || o_recall_hits !== exp_recall[0]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: precision exp %0d got %0d, recall exp %0d got %0d",
                                 exp_precision[0], o_precision_hits, exp_recall[0], o_recall_hits);
                end
                void'(exp_precision.pop_front());
                void'(exp_recall.pop_front());
            end
        end
        if (i_rst_n && i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == rprc_pkg::CFG_IMAGE_WIDTH) cur_w = i_cfg_data;
            else if (i_cfg_index == rprc_pkg::CFG_IMAGE_HEIGHT) cur_h = i_cfg_data;
            else if (i_cfg_index == rprc_pkg::CFG_RELAX_RADIUS) cur_r = i_cfg_data[2:0];
            if (i_cfg_index <= rprc_pkg::CFG_RELAX_RADIUS) begin
                col = 0;
                row = 0;
            end
        end
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            w = (cur_w < 1) ? 1 : (cur_w > 1024) ? 1024 : cur_w;
            h = (cur_h < 1) ? 1 : (cur_h > 1024) ? 1024 : cur_h;
            r = (cur_r > 7) ? 7 : cur_r;
            if (col >= w || row >= h) begin
                col = 0;
                row = 0;
            end
            frame_flags[row*w+col] = {i_label_value != rprc_pkg::CLASS_ZERO,
                                      i_label_value == rprc_pkg::CLASS_ONE,
                                      i_pred_value == rprc_pkg::CLASS_ONE};
            col++;
            if (col >= w) begin
                col = 0;
                row++;
                if (row >= h) begin
                    row = 0;
                    exp_precision.push_back(window_hits(w, h, r, 0, 1));
                    exp_recall.push_back(window_hits(w, h, r, 2, 0));
                end
            end
        end
    end

    // Pixel driver: changes on the falling edge.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (in_gap > 0) begin
                in_gap <= in_gap - 1;
                i_in_valid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                in_gap <= $urandom_range(0, 9);
                i_in_valid <= 1'b0;
            end else if (pixel_queue.size() > 0) begin
                i_in_valid <= 1'b1;
                i_pred_value <= pixel_queue[0].pred;
                i_label_value <= pixel_queue[0].label;
                void'(pixel_queue.pop_front());
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result stall: random bursts, plus one long hold-off.
    always @(negedge i_clk) begin
        if (long_hold && hold_cnt == 0) begin
            hold_cnt <= 400;
            long_hold = 0;
            i_out_stall <= 1'b1;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            i_out_stall <= 1'b1;
        end else if (out_burst > 0) begin
            out_burst <= out_burst - 1;
            i_out_stall <= 1'b1;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            out_burst <= $urandom_range(0, 9);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic cfg_write(logic [rprc_pkg::CFG_IDX_W-1:0] idx, int unsigned value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value[rprc_pkg::CFG_DATA_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic configure(int unsigned w, int unsigned h, int unsigned r);
        cfg_write(rprc_pkg::CFG_IMAGE_WIDTH, w);
        cfg_write(rprc_pkg::CFG_IMAGE_HEIGHT, h);
        cfg_write(rprc_pkg::CFG_RELAX_RADIUS, r);
    endtask

    task automatic push_pixel(logic [7:0] p, logic [7:0] l);
        pixel_queue.push_back('{pred: p, label: l});
    endtask

    task automatic push_random(int n);
        logic [7:0] p, l;
        for (int i = 0; i < n; i++) begin
            p = ($urandom_range(0, 2) == 0) ? rprc_pkg::CLASS_ONE : $urandom_range(0, 255);
            case ($urandom_range(0, 4))
                0, 1: l = rprc_pkg::CLASS_ONE;
                2: l = rprc_pkg::CLASS_ZERO;
                default: l = $urandom_range(0, 255);
            endcase
            push_pixel(p, l);
        end
    endtask

    task automatic settle();
        while (pixel_queue.size() > 0 || i_in_valid || exp_precision.size() > 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    initial begin
        int w, h, frames;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_pred_value = '0;
        i_label_value = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        configure(1, 1, 0);
        push_pixel(rprc_pkg::CLASS_ONE, rprc_pkg::CLASS_ONE);
        push_pixel(rprc_pkg::CLASS_ONE, 8'd255);
        push_pixel(8'd255, rprc_pkg::CLASS_ZERO);
        settle();
        configure(0, 0, 7);
        push_pixel(rprc_pkg::CLASS_ONE, rprc_pkg::CLASS_ONE);
        push_pixel(rprc_pkg::CLASS_ZERO, 8'd2);
        settle();
        configure(3, 2, 1);
        push_pixel(rprc_pkg::CLASS_ONE, rprc_pkg::CLASS_ZERO);
        push_pixel(8'd255, 8'd255);
        push_pixel(rprc_pkg::CLASS_ZERO, rprc_pkg::CLASS_ONE);
        push_pixel(rprc_pkg::CLASS_ONE, 8'd128);
        push_pixel(8'd170, 8'd85);
        push_pixel(rprc_pkg::CLASS_ONE, rprc_pkg::CLASS_ONE);
        push_pixel(rprc_pkg::CLASS_ONE, rprc_pkg::CLASS_ONE);
        push_pixel(rprc_pkg::CLASS_ZERO, rprc_pkg::CLASS_ONE);
        settle();
        // A partial frame is dropped by the next register write.
        cfg_write(rprc_pkg::CFG_RELAX_RADIUS, 2);
        push_random(3);
        settle();

        configure(2, 2, 1);
        long_hold = 1;
        push_random(40);
        settle();

        while (sent_random < 640) begin
            if (sent_random > 540) quiet = 1;
            w = $urandom_range(1, 16);
            h = $urandom_range(1, 10);
            configure(w, h, $urandom_range(0, 7));
            frames = $urandom_range(1, 3);
            push_random(w * h * frames);
            sent_random += w * h * frames;
            settle();
        end

        if (mismatches == 0 && exp_precision.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("== FAIL ==");
        $finish;
    end
endmodule

### relaxed_precision_recall_counter.f
rtl/rprc_pkg.sv
rtl/rprc_ram.sv
rtl/rprc_cell.sv
rtl/relaxed_precision_recall_counter.sv
verif/testbench.sv
